// ----- hw/rtl/assert_macros.svh -----
// Assertion macro used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// Shared types and constants of the I2C master bit engine.
// No dependencies.
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_WRITE   = 3'd3;
    localparam logic [2:0] CMD_WAITACK = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;
    localparam logic [2:0] CMD_ACK     = 3'd6;
    localparam logic [2:0] CMD_NACK    = 3'd7;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd30;
    localparam int          QUEUE_DEPTH_DEF   = 4;
    localparam int          LAST_BIT          = 7;

    // one timebase tick, classified
    typedef struct packed {
        logic       start_req;
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       sda_in;
    } tick_item_t;

    // queue head towards the sequencer
    typedef struct packed {
        logic       avail;
        tick_item_t item;
    } q_head_t;

endpackage

`default_nettype wire

// ----- hw/rtl/i2c_master_bit_engine_core.sv -----
// I2C master bit engine, top level: tick queue and bus phase sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
// Each request is one timebase tick and yields one result carrying the SCL
// and SDA drive levels, ready and done flags, the last read byte and the
// last acknowledge. One request is taken every clock cycle while the queue
// is not full; it passes through the tick queue, then the output register.
// The rate is set by the sequencer, which advances its bus state by one
// tick per cycle while the output is not stalled. The queue holds QUEUE_DEPTH
// ticks so the input keeps flowing while a result waits. The user writes
// phase_ticks via cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
`default_nettype none

module i2c_master_bit_engine_core #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        sda_in,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             scl_out,
    output logic             sda_out,
    output logic             ready_res,
    output logic             done_res,
    output logic [7:0]       rx_byte,
    output logic             ack_bit
);

    i2cm_pkg::q_head_t head;
    logic              pop;

    i2cm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .tx_byte  (tx_byte),
        .sda_in   (sda_in),
        .head     (head),
        .pop      (pop)
    );

    i2cm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_out     (scl_out),
        .sda_out     (sda_out),
        .ready_res   (ready_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_bit     (ack_bit)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/i2cm_front.sv -----
// Front end: accepts timebase ticks, classifies them and queues them.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           cmd,
    input  wire logic [7:0]           tx_byte,
    input  wire logic                 sda_in,
    output i2cm_pkg::q_head_t         head,
    input  wire logic                 pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    i2cm_pkg::tick_item_t store_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;
    logic          do_pop;
    i2cm_pkg::tick_item_t new_item;

    assign in_stall = (count_reg == CW'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        new_item.start_req = (cmd != i2cm_pkg::CMD_NONE);
        new_item.cmd       = cmd;
        new_item.tx_byte   = tx_byte;
        new_item.sda_in    = sda_in;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.avail = (count_reg != '0);
    assign head.item  = store_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- hw/rtl/i2cm_back.sv -----
// Back end: bus phase sequencer, phase_ticks register and output register.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [15:0]          cfg_wr_data,
    input  wire i2cm_pkg::q_head_t    head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      scl_out,
    output logic                      sda_out,
    output logic                      ready_res,
    output logic                      done_res,
    output logic [7:0]                rx_byte,
    output logic                      ack_bit
);

    typedef enum logic [2:0] {
        S_IDLE    = i2cm_pkg::CMD_NONE,
        S_START   = i2cm_pkg::CMD_START,
        S_STOP    = i2cm_pkg::CMD_STOP,
        S_WRITE   = i2cm_pkg::CMD_WRITE,
        S_WAITACK = i2cm_pkg::CMD_WAITACK,
        S_READ    = i2cm_pkg::CMD_READ,
        S_ACK     = i2cm_pkg::CMD_ACK,
        S_NACK    = i2cm_pkg::CMD_NACK
    } seq_t;

    typedef struct packed {
        logic scl;
        logic sda;
    } lines_t;

    seq_t        state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  rx_reg, rx_next;
    lines_t      lines_reg, lines_next;
    logic        ack_reg, ack_next;
    logic        done_next;
    logic [15:0] phase_ticks_reg;
    logic        out_valid_reg;
    logic        scl_reg, sda_reg, ready_reg, done_reg, ackout_reg;
    logic [7:0]  rxout_reg;
    logic [15:0] limit;

    function automatic lines_t enter_phase(seq_t st, logic [1:0] ph, logic msb,
                                           logic last_bit, lines_t cur);
        lines_t r;
        r = cur;
        case (st)
            S_START:
            begin
                if (ph == 2'd0)
                begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end
                else if (ph == 2'd1) r.sda = 1'b0;
                else                 r.scl = 1'b0;
            end
            S_STOP:
            begin
                r.sda = 1'b0;
                r.scl = 1'b1;
            end
            S_WRITE:
            begin
                if (ph == 2'd0)      r.sda = msb;
                else if (ph == 2'd1) r.scl = 1'b1;
                else
                begin
                    r.scl = 1'b0;
                    if (last_bit) r.sda = 1'b1;
                end
            end
            S_READ:
            begin
                r.scl = (ph == 2'd0);
            end
            S_WAITACK, S_ACK, S_NACK:
            begin
                if (ph == 2'd0)      r.sda = (st != S_ACK);
                else if (ph == 2'd1) r.scl = 1'b1;
                else                 r.scl = 1'b0;
            end
            default:
            begin
                r = cur;
            end
        endcase
        return r;
    endfunction

    assign pop   = head.avail && (!out_valid_reg || !out_stall);
    assign limit = (phase_ticks_reg == '0) ? 16'd1 : phase_ticks_reg;

    always_comb
    begin
        logic finish;
        state_next = state_reg;
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        lines_next = lines_reg;
        ack_next   = ack_reg;
        done_next  = 1'b0;
        finish     = 1'b0;
        if (state_reg == S_IDLE)
        begin
            if (head.item.start_req)
            begin
                state_next = seq_t'(head.item.cmd);
                bit_next   = '0;
                shift_next = (head.item.cmd == i2cm_pkg::CMD_WRITE) ? head.item.tx_byte : 8'h00;
                phase_next = 2'd0;
                tick_next  = '0;
                lines_next = enter_phase(state_next, 2'd0, shift_next[7], 1'b0, lines_reg);
            end
        end
        else
        begin
            tick_next = tick_reg + 16'd1;
            if (tick_next >= limit)
            begin
                tick_next = '0;
                case (state_reg)
                    S_START, S_NACK:
                    begin
                        if (phase_reg < 2'd2) phase_next = phase_reg + 2'd1;
                        else                  finish = 1'b1;
                    end
                    S_STOP:
                    begin
                        lines_next.sda = 1'b1;
                        finish = 1'b1;
                    end
                    S_WRITE:
                    begin
                        if (phase_reg < 2'd2) phase_next = phase_reg + 2'd1;
                        else if (bit_reg != 3'(i2cm_pkg::LAST_BIT))
                        begin
                            bit_next   = bit_reg + 3'd1;
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = 2'd0;
                        end
                        else finish = 1'b1;
                    end
                    S_WAITACK:
                    begin
                        if (phase_reg == 2'd1) ack_next = head.item.sda_in;
                        if (phase_reg < 2'd2) phase_next = phase_reg + 2'd1;
                        else                  finish = 1'b1;
                    end
                    S_READ:
                    begin
                        if (phase_reg == 2'd0)
                        begin
                            shift_next = {shift_reg[6:0], head.item.sda_in};
                            phase_next = 2'd1;
                        end
                        else if (bit_reg != 3'(i2cm_pkg::LAST_BIT))
                        begin
                            bit_next   = bit_reg + 3'd1;
                            phase_next = 2'd0;
                        end
                        else
                        begin
                            rx_next = shift_reg;
                            finish  = 1'b1;
                        end
                    end
                    S_ACK:
                    begin
                        if (phase_reg < 2'd2) phase_next = phase_reg + 2'd1;
                        else
                        begin
                            lines_next.sda = 1'b1;
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
                if (finish)
                begin
                    state_next = S_IDLE;
                    phase_next = 2'd0;
                    bit_next   = '0;
                    done_next  = 1'b1;
                end
                else
                begin
                    lines_next = enter_phase(state_reg, phase_next, shift_next[7],
                                             (bit_next == 3'(i2cm_pkg::LAST_BIT)),
                                             lines_reg);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            phase_reg       <= '0;
            tick_reg        <= '0;
            bit_reg         <= '0;
            shift_reg       <= '0;
            rx_reg          <= '0;
            lines_reg       <= '{scl: 1'b1, sda: 1'b1};
            ack_reg         <= 1'b0;
            phase_ticks_reg <= i2cm_pkg::PHASE_TICKS_RESET;
            out_valid_reg   <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            ready_reg       <= 1'b1;
            done_reg        <= 1'b0;
            rxout_reg       <= '0;
            ackout_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_ticks_reg <= cfg_wr_data;
            end
            out_valid_reg <= pop || (out_valid_reg && out_stall);
            if (pop)
            begin
                state_reg  <= state_next;
                phase_reg  <= phase_next;
                tick_reg   <= tick_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                rx_reg     <= rx_next;
                lines_reg  <= lines_next;
                ack_reg    <= ack_next;
                scl_reg    <= lines_next.scl;
                sda_reg    <= lines_next.sda;
                ready_reg  <= (state_next == S_IDLE);
                done_reg   <= done_next;
                rxout_reg  <= rx_next;
                ackout_reg <= ack_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_reg;
    assign ready_res = ready_reg;
    assign done_res  = done_reg;
    assign rx_byte   = rxout_reg;
    assign ack_bit   = ackout_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/i2cm_checker.sv -----
// Port-level checks for the I2C master bit engine, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module i2cm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_wr_en,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [2:0]  cmd,
    input wire logic [7:0]  tx_byte,
    input wire logic        sda_in,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        scl_out,
    input wire logic        sda_out,
    input wire logic        ready_res,
    input wire logic        done_res,
    input wire logic [7:0]  rx_byte,
    input wire logic        ack_bit
);

    // stalled result holds
    `CHK_ASSERT(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable({scl_out, sda_out, ready_res,
        done_res, rx_byte, ack_bit}), "stalled result changed")

    // stalled request holds
    `CHK_ASSERT(a_req_hold, clk, rst_n,
        in_valid && in_stall |=> in_valid && $stable({cmd, tx_byte, sda_in}),
        "stalled request changed")

    // a finished command leaves the engine idle
    `CHK_ASSERT(a_done_ready, clk, rst_n,
        out_valid && done_res |-> ready_res, "done without ready")

    // the queue only fills while results back up
    `CHK_ASSERT(a_stall_cause, clk, rst_n,
        in_stall |-> $past(out_valid), "input stalled with output free")

    // phase_ticks is only written while no result waits and the input is not stalled
    `CHK_ASSERT(a_cfg_quiet, clk, rst_n,
        cfg_wr_en |-> !out_valid && !in_stall, "phase_ticks written while busy")

endmodule

bind i2c_master_bit_engine_core i2cm_checker u_chk (.*);

`default_nettype wire

// ----- bench/i2c_master_bit_engine_core_test.sv -----
// Self-checking bench for i2c_master_bit_engine_core: directed table, then random
// I2C transactions, each result checked against its known table row or a cycle-exact bus sequencer predictor.
// Depends on i2cm_pkg and the engine RTL only.
module i2c_master_bit_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam int PLAN_ROWS   = 19;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       ready;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } bus_levels_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
    } bus_cmd_t;

    typedef struct packed {
        logic [15:0] period;
        logic [2:0]  op;
        logic [7:0]  data;
        logic        sda;
        logic        drain;
        logic        known;
        bus_levels_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd = i2cm_pkg::CMD_NONE;
    logic [7:0]  tx_byte = 8'h00;
    logic        sda_in = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        scl_out;
    logic        sda_out;
    logic        ready_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_bit;

    // predictor state
    logic [2:0]  eng_state = i2cm_pkg::CMD_NONE;
    logic [1:0]  eng_phase = 2'd0;
    logic [15:0] eng_ticks = 16'd0;
    logic [3:0]  eng_bit = 4'd0;
    logic [7:0]  eng_shift = 8'h00;
    logic [7:0]  eng_rx = 8'h00;
    logic        eng_scl = 1'b1;
    logic        eng_sda = 1'b1;
    logic        eng_ack = 1'b0;
    logic [15:0] eng_period = i2cm_pkg::PHASE_TICKS_RESET;

    bus_levels_t pending_levels[$];
    bus_cmd_t    script[$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          send_gap_pct = 23;
    int          stall_pct = 67;
    logic        hold_go = 1'b0;

    logic [15:0] rnd_period [4] = '{16'd1, 16'd3, 16'd2, 16'd0};
    int          rnd_gap    [4] = '{23, 67, 0, 0};
    int          rnd_stall  [4] = '{67, 23, 0, 0};
    int          rnd_len    [4] = '{150, 150, 120, 120};

    plan_row_t plan [PLAN_ROWS] = '{
        '{16'd30, i2cm_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b1,
          {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{16'd30, i2cm_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b0, 1'b1,
          {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{16'd30, i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b1,
          {1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{16'd1, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b1,
          {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{16'd1, i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0, '0},
        // read offered while the write runs: ignored
        '{16'd1, i2cm_pkg::CMD_READ, 8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{16'd1, i2cm_pkg::CMD_WAITACK, 8'h00, 1'b1, 1'b1, 1'b0, '0},
        '{16'd1, i2cm_pkg::CMD_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{16'd1, i2cm_pkg::CMD_WAITACK, 8'hFF, 1'b0, 1'b1, 1'b0, '0},
        // zero phase length behaves as one tick
        '{16'd0, i2cm_pkg::CMD_READ, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{16'd0, i2cm_pkg::CMD_ACK, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{16'd0, i2cm_pkg::CMD_READ, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
        '{16'd0, i2cm_pkg::CMD_NACK, 8'hFF, 1'b1, 1'b1, 1'b0, '0},
        '{16'd2, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{16'd2, i2cm_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{16'd2, i2cm_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0, 1'b1,
          {1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0}},
        '{16'hFFFF, i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        '{16'hFFFF, i2cm_pkg::CMD_NONE, 8'hFF, 1'b1, 1'b0, 1'b0, '0},
        '{16'hFFFF, i2cm_pkg::CMD_WRITE, 8'hFF, 1'b1, 1'b0, 1'b0, '0}
    };

    i2c_master_bit_engine_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .tx_byte     (tx_byte),
        .sda_in      (sda_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .scl_out     (scl_out),
        .sda_out     (sda_out),
        .ready_res   (ready_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_bit     (ack_bit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void load_phase(input logic [1:0] p);
        eng_phase = p;
        eng_ticks = 16'd0;
        case (eng_state)
            i2cm_pkg::CMD_START:
            begin
                if (p == 2'd0)
                begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end
                else if (p == 2'd1)
                    eng_sda = 1'b0;
                else
                    eng_scl = 1'b0;
            end
            i2cm_pkg::CMD_STOP:
            begin
                eng_sda = 1'b0;
                eng_scl = 1'b1;
            end
            i2cm_pkg::CMD_WRITE:
            begin
                if (p == 2'd0)
                    eng_sda = eng_shift[7];
                else if (p == 2'd1)
                    eng_scl = 1'b1;
                else
                begin
                    eng_scl = 1'b0;
                    if (eng_bit >= 4'd7)
                        eng_sda = 1'b1;
                end
            end
            i2cm_pkg::CMD_READ:
                eng_scl = (p == 2'd0);
            i2cm_pkg::CMD_WAITACK, i2cm_pkg::CMD_ACK, i2cm_pkg::CMD_NACK:
            begin
                if (p == 2'd0)
                    eng_sda = (eng_state != i2cm_pkg::CMD_ACK);
                else if (p == 2'd1)
                    eng_scl = 1'b1;
                else
                    eng_scl = 1'b0;
            end
            default: ;
        endcase
    endfunction

    // one timebase tick through the bus sequencer
    function automatic void advance_engine(input logic [2:0] c, input logic [7:0] t,
                                           input logic s, output bus_levels_t lv);
        logic [16:0] lim;
        logic        fin;
        fin = 1'b0;
        if (eng_state == i2cm_pkg::CMD_NONE)
        begin
            if (c != i2cm_pkg::CMD_NONE)
            begin
                eng_state = c;
                eng_bit = 4'd0;
                eng_shift = (c == i2cm_pkg::CMD_WRITE) ? t : 8'h00;
                load_phase(2'd0);
            end
        end
        else
        begin
            lim = (eng_period == 16'd0) ? 17'd1 : {1'b0, eng_period};
            eng_ticks = eng_ticks + 16'd1;
            if ({1'b0, eng_ticks} >= lim)
            begin
                fin = 1'b1;
                case (eng_state)
                    i2cm_pkg::CMD_START, i2cm_pkg::CMD_NACK:
                        if (eng_phase < 2'd2)
                        begin
                            load_phase(eng_phase + 2'd1);
                            fin = 1'b0;
                        end
                    i2cm_pkg::CMD_STOP:
                        eng_sda = 1'b1;
                    i2cm_pkg::CMD_WRITE:
                        if (eng_phase < 2'd2)
                        begin
                            load_phase(eng_phase + 2'd1);
                            fin = 1'b0;
                        end
                        else if (eng_bit < 4'd7)
                        begin
                            eng_bit = eng_bit + 4'd1;
                            eng_shift = {eng_shift[6:0], 1'b0};
                            load_phase(2'd0);
                            fin = 1'b0;
                        end
                    i2cm_pkg::CMD_WAITACK:
                    begin
                        if (eng_phase == 2'd1)
                            eng_ack = s;
                        if (eng_phase < 2'd2)
                        begin
                            load_phase(eng_phase + 2'd1);
                            fin = 1'b0;
                        end
                    end
                    i2cm_pkg::CMD_READ:
                        if (eng_phase == 2'd0)
                        begin
                            eng_shift = {eng_shift[6:0], s};
                            load_phase(2'd1);
                            fin = 1'b0;
                        end
                        else if (eng_bit < 4'd7)
                        begin
                            eng_bit = eng_bit + 4'd1;
                            load_phase(2'd0);
                            fin = 1'b0;
                        end
                        else
                            eng_rx = eng_shift;
                    i2cm_pkg::CMD_ACK:
                        if (eng_phase < 2'd2)
                        begin
                            load_phase(eng_phase + 2'd1);
                            fin = 1'b0;
                        end
                        else
                            eng_sda = 1'b1;
                    default: ;
                endcase
                if (fin)
                begin
                    eng_state = i2cm_pkg::CMD_NONE;
                    eng_phase = 2'd0;
                    eng_ticks = 16'd0;
                    eng_bit = 4'd0;
                end
            end
        end
        lv.scl = eng_scl;
        lv.sda = eng_sda;
        lv.ready = (eng_state == i2cm_pkg::CMD_NONE);
        lv.done = fin;
        lv.rx = eng_rx;
        lv.ack = eng_ack;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatches++;
        $display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
    endtask

    task automatic send_tick(input logic [2:0] c, input logic [7:0] t, input logic s,
                             input logic known, input bus_levels_t want);
        bus_levels_t lv;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        tx_byte <= t;
        sda_in <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_engine(c, t, s, lv);
        pending_levels.push_back(known ? want : lv);
    endtask

    // quiet the request side, let every result drain, then rewrite phase_ticks
    task automatic set_period(input logic [15:0] v);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_levels.size() != 0)
            @(negedge clk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        eng_period = v;
    endtask

    always @(posedge clk)
    begin
        bus_levels_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_levels.size() == 0)
                note_mismatch("result with no request pending", 8'h00, 8'h00);
            else
            begin
                want = pending_levels.pop_front();
                if (scl_out !== want.scl)
                    note_mismatch("scl_out", 8'(scl_out), 8'(want.scl));
                if (sda_out !== want.sda)
                    note_mismatch("sda_out", 8'(sda_out), 8'(want.sda));
                if (ready_res !== want.ready)
                    note_mismatch("ready_res", 8'(ready_res), 8'(want.ready));
                if (done_res !== want.done)
                    note_mismatch("done_res", 8'(done_res), 8'(want.done));
                if (rx_byte !== want.rx)
                    note_mismatch("rx_byte", rx_byte, want.rx);
                if (ack_bit !== want.ack)
                    note_mismatch("ack_bit", 8'(ack_bit), 8'(want.ack));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("i2c_master_bit_engine_core_test: errors");
            $finish;
        end
    end

    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin : sender
        int       r;
        int       n;
        int       ph;
        int       k;
        logic [2:0] c;
        logic [7:0] t;
        logic     s;
        bus_cmd_t step;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].period != eng_period)
                set_period(plan[r].period);
            send_tick(plan[r].op, plan[r].data, plan[r].sda, plan[r].known, plan[r].want);
            if (plan[r].drain)
                while (eng_state != i2cm_pkg::CMD_NONE)
                    send_tick(plan[r].op, plan[r].data, plan[r].sda, 1'b0, '0);
        end

        for (ph = 0; ph < 4; ph++)
        begin
            set_period(rnd_period[ph]);
            send_gap_pct = rnd_gap[ph];
            stall_pct <= rnd_stall[ph];
            if (ph == 2)
                hold_go <= 1'b1;
            for (n = 0; n < rnd_len[ph]; n++)
            begin
                c = i2cm_pkg::CMD_NONE;
                t = 8'($urandom);
                s = 1'($urandom);
                if (eng_state != i2cm_pkg::CMD_NONE)
                    c = 3'($urandom_range(7));
                else if ($urandom_range(99) < 8)
                    c = 3'($urandom_range(7));
                else if ($urandom_range(99) >= 10)
                begin
                    // a broken transaction now and then: drop the rest of the script
                    if (script.size() == 0 || $urandom_range(99) < 3)
                    begin
                        script.delete();
                        script.push_back(bus_cmd_t'{i2cm_pkg::CMD_START, 8'h00});
                        script.push_back(bus_cmd_t'{i2cm_pkg::CMD_WRITE, 8'($urandom)});
                        script.push_back(bus_cmd_t'{i2cm_pkg::CMD_WAITACK, 8'h00});
                        k = $urandom_range(1, 3);
                        repeat (k)
                        begin
                            if ($urandom_range(1) == 1)
                            begin
                                script.push_back(bus_cmd_t'{i2cm_pkg::CMD_WRITE,
                                                            8'($urandom)});
                                script.push_back(bus_cmd_t'{i2cm_pkg::CMD_WAITACK,
                                                            8'h00});
                            end
                            else
                            begin
                                script.push_back(bus_cmd_t'{i2cm_pkg::CMD_READ, 8'h00});
                                script.push_back(bus_cmd_t'{$urandom_range(1) == 1 ?
                                                            i2cm_pkg::CMD_ACK :
                                                            i2cm_pkg::CMD_NACK,
                                                            8'h00});
                            end
                        end
                        script.push_back(bus_cmd_t'{i2cm_pkg::CMD_STOP, 8'h00});
                    end
                    step = script.pop_front();
                    c = step.op;
                    if (step.op == i2cm_pkg::CMD_WRITE)
                        t = step.data;
                end
                send_tick(c, t, s, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_levels.size() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("i2c_master_bit_engine_core_test: clean");
        else
            $display("i2c_master_bit_engine_core_test: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_back.sv
hw/rtl/i2c_master_bit_engine_core.sv
hw/rtl/i2cm_checker.sv
bench/i2c_master_bit_engine_core_test.sv
